/* hw/rtl/mcpi_pkg.sv */
`default_nettype none

package mcpi_pkg;

   // Field widths of the channels and of the configuration registers.
   localparam int OP_W   = 2;
   localparam int CUR_W  = 12;
   localparam int PCT_W  = 8;
   localparam int DUTY_W = 12;
   localparam int EFF_W  = 13;
   localparam int GAIN_W = 16;
   localparam int ILIM_W = 20;
   localparam int CLIM_W = 11;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = ILIM_W;

   // Internal datapath widths.
   localparam int ERR_W   = CUR_W + 1;
   localparam int SUM_W   = ILIM_W + 2;
   localparam int WAVE_W  = 6;
   localparam int PROP_W  = GAIN_W + 1 + ERR_W;
   localparam int INTEG_W = GAIN_W + 1 + SUM_W;
   localparam int TOT_W   = INTEG_W + 1;
   localparam int Q_SHIFT = 8;
   localparam int QUO_W   = TOT_W - Q_SHIFT;

   // PWM timer period and the largest drive magnitude it allows.
   localparam int PWM_TOP = 4000;
   localparam int EFF_MAX = PWM_TOP - 1;

   // Open-loop percent scaling: mag * EFF_MAX / 100 is split into a whole part
   // mag * (EFF_MAX / 100) and a small fraction mag * (EFF_MAX % 100) / 100,
   // the latter divided through a rounded-up reciprocal.
   localparam int PCT_MAX   = 100;
   localparam int MAG_W     = $clog2(PCT_MAX + 1);
   localparam int PWM_WHOLE = EFF_MAX / PCT_MAX;
   localparam int PWM_REM   = EFF_MAX % PCT_MAX;
   localparam int WHOLE_W   = $clog2(PCT_MAX * PWM_WHOLE + 1);
   localparam int REMP_W    = $clog2(PCT_MAX * (PCT_MAX - 1) + 1);
   localparam int FRAC_W    = $clog2(PCT_MAX);
   localparam int FRAC_SH   = REMP_W + $clog2(PCT_MAX);
   localparam int RECIP     = (2 ** FRAC_SH + PCT_MAX - 1) / PCT_MAX;
   localparam int RECIP_W   = FRAC_SH + 1 - $clog2(PCT_MAX);
   localparam int FPROD_W   = REMP_W + RECIP_W;

   // Tuning square wave.
   localparam int TUNE_HALF = 25;
   localparam int TUNE_FULL = 50;
   localparam int TUNE_AMP  = 100;

   // Reset values of the configuration registers (8.25 and 1.25 in Q8.8).
   localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = GAIN_W'(2112);
   localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = GAIN_W'(320);
   localparam logic [ILIM_W-1:0] ILIM_RST       = '0;
   localparam logic [CLIM_W-1:0] CLIM_RST       = CLIM_W'(1000);

   typedef enum logic [OP_W-1:0] {
      OP_IDLE  = 2'd0,
      OP_PWM   = 2'd1,
      OP_TUNE  = 2'd2,
      OP_TRACK = 2'd3
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PROP_GAIN      = 4'd0,
      CSR_INTEG_GAIN     = 4'd1,
      CSR_INTEGRAL_LIMIT = 4'd2,
      CSR_CURRENT_LIMIT  = 4'd3
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0] prop_gain;
      logic [GAIN_W-1:0] integ_gain;
      logic [ILIM_W-1:0] integral_limit;
      logic [CLIM_W-1:0] current_limit_ma;
   } cfg_type;

   // Error stage output.
   typedef struct packed {
      opcode_type              op;
      logic signed [ERR_W-1:0] err;
      logic                    pwm_neg;
      logic [MAG_W-1:0]        pwm_mag;
   } err_stage_type;

   // Integrator stage output.
   typedef struct packed {
      opcode_type              op;
      logic signed [ERR_W-1:0] err;
      logic signed [SUM_W-1:0] error_sum;
      logic                    pwm_neg;
      logic [MAG_W-1:0]        pwm_mag;
      logic [REMP_W-1:0]       pwm_rem_prod;
   } integ_stage_type;

   // Multiplier stage output.
   typedef struct packed {
      opcode_type                op;
      logic signed [PROP_W-1:0]  prop_term;
      logic signed [INTEG_W-1:0] integ_term;
      logic                      pwm_neg;
      logic [WHOLE_W-1:0]        pwm_whole;
      logic [FRAC_W-1:0]         pwm_frac;
   } mult_stage_type;

endpackage

`default_nettype wire

/* hw/rtl/mcpi_if.sv */
`default_nettype none

interface mcpi_req_if;
   logic                    valid;
   logic                    ready;
   logic [1:0]              opcode;
   logic signed [11:0]      sensor_ma;
   logic signed [11:0]      ref_ma;
   logic signed [7:0]       open_loop_pct;

   modport source (output valid, opcode, sensor_ma, ref_ma, open_loop_pct, input ready);
   modport sink (input valid, opcode, sensor_ma, ref_ma, open_loop_pct, output ready);
endinterface

interface mcpi_rsp_if;
   logic                    valid;
   logic                    ready;
   logic [11:0]             duty;
   logic                    direction;
   logic signed [12:0]      effort;

   modport source (output valid, duty, direction, effort, input ready);
   modport sink (input valid, duty, direction, effort, output ready);
endinterface

interface mcpi_csr_if;
   logic                    valid;
   logic                    ready;
   logic [3:0]              index;
   logic [19:0]             wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

/* hw/rtl/mcpi_mult.sv */
`default_nettype none

// Product stage: PI gain products and the open-loop percent scaling.
module mcpi_mult
   import mcpi_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire cfg_type         cfg,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire integ_stage_type in_data,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output mult_stage_type       out_data
);

   logic           valid_ff;
   mult_stage_type data_ff;
   mult_stage_type data_in;
   logic [FPROD_W-1:0] frac_prod;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      frac_prod = FPROD_W'(in_data.pwm_rem_prod) * FPROD_W'(RECIP);
      data_in.op         = in_data.op;
      data_in.prop_term  = PROP_W'(signed'({1'b0, cfg.prop_gain})) * PROP_W'(in_data.err);
      data_in.integ_term = INTEG_W'(signed'({1'b0, cfg.integ_gain}))
                           * INTEG_W'(in_data.error_sum);
      data_in.pwm_neg    = in_data.pwm_neg;
      data_in.pwm_whole  = WHOLE_W'(in_data.pwm_mag) * WHOLE_W'(PWM_WHOLE);
      data_in.pwm_frac   = frac_prod[FRAC_SH +: FRAC_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* hw/rtl/motor_current_pi_controller_unit.sv */
`default_nettype none

// Channel   Dir  Handshake     Contents
// req_chan  in   valid/ready   opcode, sensor_ma, ref_ma, open_loop_pct (one control tick)
// rsp_chan  out  valid/ready   duty, direction, effort (one result per tick)
// csr_chan  in   valid/ready   index, wdata (register write, ready whenever out of reset)
//
// The datapath is a five-stage pipeline: input register, reference/error,
// integrator, gain products, output sum and saturation. A transaction can be
// accepted on every cycle while the output is not stalled. The product stage
// needs registered operands and a register after the 17x22-bit multiply. Reset is
// synchronous, holds both input channels not ready, and returns the gains,
// limits, integrator, wave counter and direction to their defaults.
// A stalled output only stalls the stages behind it up to the first bubble.
module motor_current_pi_controller_unit
   import mcpi_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   mcpi_req_if.sink   req_chan,
   mcpi_rsp_if.source rsp_chan,
   mcpi_csr_if.sink   csr_chan
);

   // ------------------------------------------------------------------
   // Configuration registers. Writes are only expected while the block is
   // idle, so the pipeline reads them without any shadowing.
   // ------------------------------------------------------------------
   cfg_type cfg_ff;

   assign csr_chan.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain        <= PROP_GAIN_RST;
         cfg_ff.integ_gain       <= INTEG_GAIN_RST;
         cfg_ff.integral_limit   <= ILIM_RST;
         cfg_ff.current_limit_ma <= CLIM_RST;
      end else if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_PROP_GAIN: begin
               cfg_ff.prop_gain <= csr_chan.wdata[GAIN_W-1:0];
            end
            CSR_INTEG_GAIN: begin
               cfg_ff.integ_gain <= csr_chan.wdata[GAIN_W-1:0];
            end
            CSR_INTEGRAL_LIMIT: begin
               cfg_ff.integral_limit <= csr_chan.wdata[ILIM_W-1:0];
            end
            CSR_CURRENT_LIMIT: begin
               cfg_ff.current_limit_ma <= csr_chan.wdata[CLIM_W-1:0];
            end
            default: begin
               // Indexes past the register list are dropped.
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Stage handshakes. Each stage loads when it is empty or when the stage
   // after it is loading, so bubbles are squeezed out under back-pressure.
   // ------------------------------------------------------------------
   logic in_valid_ff;
   logic err_valid_ff;
   logic integ_valid_ff;
   logic mult_valid;
   logic out_valid_ff;

   logic in_ready;
   logic err_ready;
   logic integ_ready;
   logic mult_ready;
   logic out_ready;

   assign out_ready   = !out_valid_ff || rsp_chan.ready;
   assign integ_ready = !integ_valid_ff || mult_ready;
   assign err_ready   = !err_valid_ff || integ_ready;
   assign in_ready    = !in_valid_ff || err_ready;

   assign req_chan.ready = in_ready && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         err_valid_ff   <= 1'b0;
         integ_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (in_ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (err_ready) begin
            err_valid_ff <= in_valid_ff;
         end
         if (integ_ready) begin
            integ_valid_ff <= err_valid_ff;
         end
         if (out_ready) begin
            out_valid_ff <= mult_valid;
         end
      end
   end

   // ------------------------------------------------------------------
   // Input register.
   // ------------------------------------------------------------------
   opcode_type              op_ff;
   logic signed [CUR_W-1:0] sensor_ff;
   logic signed [CUR_W-1:0] ref_ff;
   logic signed [PCT_W-1:0] pct_ff;

   always_ff @(posedge clock) begin
      if (in_ready && req_chan.valid) begin
         op_ff     <= opcode_type'(req_chan.opcode);
         sensor_ff <= req_chan.sensor_ma;
         ref_ff    <= req_chan.ref_ma;
         pct_ff    <= req_chan.open_loop_pct;
      end
   end

   // ------------------------------------------------------------------
   // Reference and error stage. The tuning wave counter lives here and advances
   // once per tuning tick, in tick order; any other tick resets it to zero.
   // ------------------------------------------------------------------
   logic [WAVE_W-1:0]       wave_ff;
   logic [WAVE_W-1:0]       wave_in;
   logic [WAVE_W:0]         wave_plus;
   logic signed [CUR_W-1:0] ref_raw;
   logic signed [CUR_W-1:0] ref_lim;
   logic signed [CUR_W-1:0] ref_lim_neg;
   logic signed [CUR_W-1:0] ref_clamped;
   logic signed [PCT_W-1:0] pct_clamped;
   logic signed [PCT_W-1:0] pct_abs;
   err_stage_type           err_in;
   err_stage_type           err_ff;

   always_comb begin
      wave_plus   = {1'b0, wave_ff} + (WAVE_W + 1)'(1);
      wave_in     = '0;
      ref_raw     = ref_ff;
      ref_lim     = signed'({1'b0, cfg_ff.current_limit_ma});
      ref_lim_neg = -ref_lim;

      case (op_ff)
         OP_TUNE: begin
            // Square wave: negative half, then positive half. A counter found
            // past the end of the wave gives a zero reference and wraps.
            if (wave_ff < WAVE_W'(TUNE_HALF)) begin
               ref_raw = CUR_W'(-TUNE_AMP);
            end else if (wave_ff < WAVE_W'(TUNE_FULL)) begin
               ref_raw = CUR_W'(TUNE_AMP);
            end else begin
               ref_raw = '0;
            end
            if (wave_plus >= (WAVE_W + 1)'(TUNE_FULL)) begin
               wave_in = WAVE_W'(wave_plus - (WAVE_W + 1)'(TUNE_FULL));
            end else begin
               wave_in = WAVE_W'(wave_plus);
            end
         end
         default: begin
            ref_raw = ref_ff;
            wave_in = '0;
         end
      endcase

      if (ref_raw > ref_lim) begin
         ref_clamped = ref_lim;
      end else if (ref_raw < ref_lim_neg) begin
         ref_clamped = ref_lim_neg;
      end else begin
         ref_clamped = ref_raw;
      end

      if (pct_ff > PCT_W'(PCT_MAX)) begin
         pct_clamped = PCT_W'(PCT_MAX);
      end else if (pct_ff < PCT_W'(-PCT_MAX)) begin
         pct_clamped = PCT_W'(-PCT_MAX);
      end else begin
         pct_clamped = pct_ff;
      end
      pct_abs = (pct_clamped < 0) ? -pct_clamped : pct_clamped;

      err_in.op      = op_ff;
      err_in.err     = ERR_W'(ref_clamped) - ERR_W'(sensor_ff);
      err_in.pwm_neg = pct_clamped < 0;
      err_in.pwm_mag = MAG_W'(pct_abs);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff <= '0;
      end else if (err_ready && in_valid_ff) begin
         wave_ff <= wave_in;
      end
   end

   always_ff @(posedge clock) begin
      if (err_ready && in_valid_ff) begin
         err_ff <= err_in;
      end
   end

   // ------------------------------------------------------------------
   // Integrator stage with anti-windup clamp. Idle and open-loop ticks
   // clear the accumulated error.
   // ------------------------------------------------------------------
   logic signed [SUM_W-1:0] error_sum_ff;
   logic signed [SUM_W-1:0] error_sum_in;
   logic signed [SUM_W:0]   sum_raw;
   logic signed [SUM_W:0]   sum_lim;
   logic signed [SUM_W:0]   sum_lim_neg;
   integ_stage_type         integ_in;
   integ_stage_type         integ_ff;

   always_comb begin
      sum_raw     = (SUM_W + 1)'(error_sum_ff) + (SUM_W + 1)'(err_ff.err);
      sum_lim     = signed'({3'b000, cfg_ff.integral_limit});
      sum_lim_neg = -sum_lim;

      case (err_ff.op)
         OP_TUNE, OP_TRACK: begin
            if (sum_raw > sum_lim) begin
               error_sum_in = SUM_W'(sum_lim);
            end else if (sum_raw < sum_lim_neg) begin
               error_sum_in = SUM_W'(sum_lim_neg);
            end else begin
               error_sum_in = SUM_W'(sum_raw);
            end
         end
         default: begin
            error_sum_in = '0;
         end
      endcase

      integ_in.op           = err_ff.op;
      integ_in.err          = err_ff.err;
      integ_in.error_sum    = error_sum_in;
      integ_in.pwm_neg      = err_ff.pwm_neg;
      integ_in.pwm_mag      = err_ff.pwm_mag;
      integ_in.pwm_rem_prod = REMP_W'(err_ff.pwm_mag) * REMP_W'(PWM_REM);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff <= '0;
      end else if (integ_ready && err_valid_ff) begin
         error_sum_ff <= error_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (integ_ready && err_valid_ff) begin
         integ_ff <= integ_in;
      end
   end

   // ------------------------------------------------------------------
   // Gain products.
   // ------------------------------------------------------------------
   mult_stage_type mult_data;

   mcpi_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (integ_valid_ff),
      .in_ready  (mult_ready),
      .in_data   (integ_ff),
      .out_valid (mult_valid),
      .out_ready (out_ready),
      .out_data  (mult_data)
   );

   // ------------------------------------------------------------------
   // Output stage: PI sum scaled by 1/256 with truncation toward zero,
   // saturation to the PWM range, and the duty/direction split. The
   // output register also holds the last direction, which idle repeats.
   // ------------------------------------------------------------------
   logic signed [TOT_W-1:0] pi_total;
   logic signed [TOT_W-1:0] pi_biased;
   logic signed [QUO_W-1:0] pi_quot;
   logic signed [EFF_W-1:0] pi_effort;
   logic [DUTY_W-1:0]       pwm_abs;
   logic signed [EFF_W-1:0] pwm_effort;
   logic signed [EFF_W-1:0] effort_in;
   logic [DUTY_W-1:0]       duty_in;
   logic                    direction_in;

   logic [DUTY_W-1:0]       duty_ff;
   logic                    direction_ff;
   logic signed [EFF_W-1:0] effort_ff;

   always_comb begin
      pi_total  = TOT_W'(mult_data.prop_term) + TOT_W'(mult_data.integ_term);
      pi_biased = pi_total
                  + ((pi_total < 0) ? TOT_W'((2 ** Q_SHIFT) - 1) : TOT_W'(0));
      pi_quot   = pi_biased[TOT_W-1:Q_SHIFT];
      if (pi_quot > QUO_W'(EFF_MAX)) begin
         pi_effort = EFF_W'(EFF_MAX);
      end else if (pi_quot < QUO_W'(-EFF_MAX)) begin
         pi_effort = EFF_W'(-EFF_MAX);
      end else begin
         pi_effort = EFF_W'(pi_quot);
      end

      pwm_abs    = DUTY_W'(mult_data.pwm_whole) + DUTY_W'(mult_data.pwm_frac);
      pwm_effort = mult_data.pwm_neg ? -signed'(EFF_W'(pwm_abs)) : signed'(EFF_W'(pwm_abs));

      case (mult_data.op)
         OP_IDLE: begin
            effort_in    = '0;
            duty_in      = '0;
            direction_in = direction_ff;
         end
         OP_PWM: begin
            effort_in    = pwm_effort;
            duty_in      = pwm_abs;
            direction_in = pwm_effort < 0;
         end
         default: begin
            effort_in    = pi_effort;
            direction_in = pi_effort < 0;
            duty_in      = (pi_effort < 0) ? DUTY_W'(-pi_effort) : DUTY_W'(pi_effort);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
      end else if (out_ready && mult_valid) begin
         direction_ff <= direction_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && mult_valid) begin
         duty_ff   <= duty_in;
         effort_ff <= effort_in;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.duty      = duty_ff;
   assign rsp_chan.direction = direction_ff;
   assign rsp_chan.effort    = effort_ff;

endmodule

`default_nettype wire

/* tb/sv/tb_motor_current_pi_controller_unit.sv */
`default_nettype none

// Self-checking bench for the motor current PI controller.
module tb_motor_current_pi_controller_unit;
   import mcpi_pkg::*;

   // Cycles with no transaction on any channel before the run is declared hung.
   localparam int QUIET_LIMIT = 1000;
   // The pipeline is five stages deep; the settle wait runs before each register set
   // is loaded, and the tail wait gives a stray result time to show up.
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 20;
   localparam int PHASE_TICKS   = 188;
   localparam int PHASE_COUNT   = 6;
   localparam int DIRECTED_ROWS = 24;

   // One control tick as the bench sees it.
   typedef struct {
      opcode_type                op;
      logic signed [CUR_W-1:0]   sensor_ma;
      logic signed [CUR_W-1:0]   ref_ma;
      logic signed [PCT_W-1:0]   open_loop_pct;
   } tick_type;

   // One drive result.
   typedef struct {
      logic [DUTY_W-1:0]         duty;
      logic                      direction;
      logic signed [EFF_W-1:0]   effort;
   } drive_type;

   // A row of the directed table. Where has_known is set, the expected drive
   // is typed into the row; otherwise the predictor supplies it.
   typedef struct {
      opcode_type op;
      int         sensor_ma;
      int         ref_ma;
      int         open_loop_pct;
      bit         has_known;
      int         duty;
      int         direction;
      int         effort;
   } directed_row_type;

   typedef struct {
      longint kp;
      longint ki;
      longint ilim;
      longint clim;
   } gain_set_type;

   logic clock;
   logic reset;

   mcpi_req_if req_bus ();
   mcpi_rsp_if rsp_bus ();
   mcpi_csr_if csr_bus ();

   motor_current_pi_controller_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Mirror of the controller's registers and state, updated at each accepted
   // tick and each accepted register write. The gains, limits, integrator and duty are held as longint so
   // that mixed signed arithmetic never silently turns unsigned.
   longint gain_p     = longint'(PROP_GAIN_RST);
   longint gain_i     = longint'(INTEG_GAIN_RST);
   longint sum_limit  = longint'(ILIM_RST);
   longint ref_limit  = longint'(CLIM_RST);
   longint integ_sum  = 0;
   int     wave_pos   = 0;
   longint duty_state = 3000;
   bit     dir_state  = 1'b0;

   // Drives that have been predicted but not yet seen on the result channel.
   drive_type pending_drives[$];

   int feed_gap_pct  = 22;
   int rsp_stall_pct = 48;
   int mismatches    = 0;
   int ticks_sent    = 0;
   int results_seen  = 0;
   int reg_writes    = 0;
   int settings_used = 0;
   int quiet_cycles  = 0;
   int op_count [4]  = '{0, 0, 0, 0};

   // The directed part, run right after reset with the default gains and a
   // zero integral limit, so the integrator stays at zero and every closed
   // loop row reduces to (8.25 * error) truncated toward zero.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{OP_IDLE,      0,     0,    0, 1'b1,    0, 0,     0},
      '{OP_PWM,       0,     0,  100, 1'b1, 3999, 0,  3999},
      '{OP_PWM,       0,     0, -100, 1'b1, 3999, 1, -3999},
      // Percentages beyond full scale saturate to the full drive.
      '{OP_PWM,    2047, -2048,  127, 1'b1, 3999, 0,  3999},
      '{OP_PWM,   -2048,  2047, -128, 1'b1, 3999, 1, -3999},
      '{OP_PWM,       0,     0,    1, 1'b1,   39, 0,    39},
      '{OP_PWM,       0,     0,   -1, 1'b1,   39, 1,   -39},
      '{OP_PWM,       0,     0,    0, 1'b1,    0, 0,     0},
      // Reference clamped to the current limit, effort saturated.
      '{OP_TRACK, -2048,  2047,    0, 1'b1, 3999, 0,  3999},
      '{OP_TRACK,  2047, -2048,    0, 1'b1, 3999, 1, -3999},
      '{OP_TRACK,     0,    10,    0, 1'b1,   82, 0,    82},
      '{OP_TRACK,     0,   -10,    0, 1'b1,   82, 1,   -82},
      // Idle zeroes the drive but keeps the last direction.
      '{OP_IDLE,      0,     0,    0, 1'b1,    0, 1,     0},
      // The tuning wave opens with its negative half.
      '{OP_TUNE,      0,     0,    0, 1'b1,  825, 1,  -825},
      '{OP_TUNE,   -100,     0,    0, 1'b1,    0, 0,     0},
      '{OP_TRACK,  1000,  1000,    0, 1'b1,    0, 0,     0},
      '{OP_TRACK,  1000,  1500,    0, 1'b1,    0, 0,     0},
      '{OP_PWM,    -777,   555,   50, 1'b1, 1999, 0,  1999},
      '{OP_TRACK,     0,    -1,    0, 1'b1,    8, 1,    -8},
      '{OP_PWM,       0,     0,  -50, 1'b1, 1999, 1, -1999},
      '{OP_IDLE,   2047,  2047,  127, 1'b1,    0, 1,     0},
      '{OP_TUNE,   2047,     0,    0, 1'b0,    0, 0,     0},
      '{OP_TRACK,   -77,   523,  -90, 1'b0,    0, 0,     0},
      '{OP_PWM,   -2048,  2047,   37, 1'b0,    0, 0,     0}
   };

   // Register settings for the random phases: defaults with room for the
   // integrator, every register at its maximum, every register at zero, a
   // mixed set, a random set (filled in at run time) and wide open limits.
   gain_set_type gain_sets [PHASE_COUNT] = '{
      '{2112,   320,   20000, 1000},
      '{65535, 65535, 1048575, 2047},
      '{0,         0,       0,    0},
      '{512,    2048,     300,  150},
      '{0,         0,       0,    0},
      '{300,       8, 1048575, 2047}
   };

   always #2 clock = ~clock;

   // The result side stalls at random according to the current phase.
   always @(posedge clock) begin
      rsp_bus.ready <= !reset && ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   function automatic longint clamp_sym(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // PI law: the integrator absorbs the error under the anti-windup clamp, the
   // Q8.8 sum is truncated toward zero and then limited to the timer range.
   function automatic longint pi_effort(longint target, longint sensor);
      longint err;
      longint sum;
      err = target - sensor;
      integ_sum = clamp_sym(integ_sum + err, sum_limit);
      sum = gain_p * err + gain_i * integ_sum;
      return clamp_sym(sum / 256, EFF_MAX);
   endfunction

   // Computes the drive for one tick and advances the mirrored state.
   function automatic drive_type predict_drive(tick_type t);
      longint sensor;
      longint target;
      longint eff;
      drive_type d;
      sensor = t.sensor_ma;
      eff = 0;
      case (t.op)
         OP_IDLE: begin
            integ_sum = 0;
            wave_pos = 0;
            duty_state = 0;
         end
         OP_PWM: begin
            integ_sum = 0;
            wave_pos = 0;
            eff = clamp_sym(t.open_loop_pct, PCT_MAX) * EFF_MAX / PCT_MAX;
         end
         OP_TUNE: begin
            if (wave_pos < TUNE_HALF) target = -TUNE_AMP;
            else if (wave_pos < TUNE_FULL) target = TUNE_AMP;
            else target = 0;
            eff = pi_effort(clamp_sym(target, ref_limit), sensor);
            wave_pos = (wave_pos + 1) % TUNE_FULL;
         end
         default: begin
            wave_pos = 0;
            eff = pi_effort(clamp_sym(t.ref_ma, ref_limit), sensor);
         end
      endcase
      if (t.op != OP_IDLE) begin
         dir_state = (eff < 0);
         duty_state = (eff < 0) ? -eff : eff;
      end
      d.duty = duty_state[DUTY_W-1:0];
      d.direction = dir_state;
      d.effort = eff[EFF_W-1:0];
      return d;
   endfunction

   // Mostly small currents around zero, now and then any 12-bit pattern so
   // that every bit of the field toggles.
   function automatic logic signed [CUR_W-1:0] rand_current();
      if ($urandom_range(0, 5) == 0) return CUR_W'($urandom);
      return CUR_W'(int'($urandom_range(0, 600)) - 300);
   endfunction

   // Half the time any 8-bit pattern, so out-of-range percentages are common.
   function automatic logic signed [PCT_W-1:0] rand_pct();
      if ($urandom_range(0, 1) == 0) return PCT_W'($urandom);
      return PCT_W'(int'($urandom_range(0, 200)) - PCT_MAX);
   endfunction

   // Offers one tick, possibly after a random gap, and records its expected
   // drive once the transaction completes. Valid is left high on return so a
   // following tick can go out on the very next cycle.
   task automatic send_tick(tick_type t, bit use_known, drive_type known);
      drive_type predicted;
      while ($urandom_range(0, 99) < feed_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.opcode        <= t.op;
      req_bus.sensor_ma     <= t.sensor_ma;
      req_bus.ref_ma        <= t.ref_ma;
      req_bus.open_loop_pct <= t.open_loop_pct;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      predicted = predict_drive(t);
      if (use_known) pending_drives.push_back(known);
      else pending_drives.push_back(predicted);
      op_count[int'(t.op)]++;
      ticks_sent++;
   endtask

   // Holds the tick channel quiet until every expected drive has come back.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_drives.size() != 0);
   endtask

   // One register write. Valid stays high on return; the caller lowers it.
   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= data;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      case (idx)
         CSR_PROP_GAIN:      gain_p = data[GAIN_W-1:0];
         CSR_INTEG_GAIN:     gain_i = data[GAIN_W-1:0];
         CSR_INTEGRAL_LIMIT: sum_limit = data[ILIM_W-1:0];
         CSR_CURRENT_LIMIT:  ref_limit = data[CLIM_W-1:0];
         default: ;
      endcase
      reg_writes++;
   endtask

   // Loads a new register set once the pipeline is empty. Unused upper data
   // bits carry random junk, and a write to an unmapped index goes first; the
   // block must ignore both.
   task automatic apply_settings(gain_set_type g);
      logic [CSR_DATA_W-1:0] junk;
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      junk = CSR_DATA_W'($urandom);
      write_reg(csr_index_type'(CSR_INDEX_W'($urandom_range(int'(CSR_CURRENT_LIMIT) + 1,
                                                            (1 << CSR_INDEX_W) - 1))),
                CSR_DATA_W'($urandom));
      write_reg(CSR_PROP_GAIN, {junk[CSR_DATA_W-1:GAIN_W], GAIN_W'(g.kp)});
      write_reg(CSR_INTEG_GAIN, {junk[CSR_DATA_W-1:GAIN_W], GAIN_W'(g.ki)});
      write_reg(CSR_INTEGRAL_LIMIT, CSR_DATA_W'(g.ilim));
      write_reg(CSR_CURRENT_LIMIT, {junk[CSR_DATA_W-1:CLIM_W], CLIM_W'(g.clim)});
      csr_bus.valid <= 1'b0;
      settings_used++;
   endtask

   // Random traffic built from bursts. Long tuning bursts walk the square wave
   // through both halves and its wrap while the integrator winds up; tracking
   // bursts hold a reference with occasional steps; short open-loop and idle
   // bursts clear the loop; noise bursts pick every mode at random.
   task automatic run_traffic(int count);
      int left;
      int burst_len;
      int pick;
      int k;
      bit noise;
      opcode_type burst_op;
      logic signed [CUR_W-1:0] hold_ref;
      tick_type t;
      drive_type unused;
      left = count;
      unused = '{'0, 1'b0, '0};
      while (left > 0) begin
         pick = $urandom_range(0, 19);
         noise = 1'b0;
         if (pick < 8) begin
            burst_op = OP_TUNE;
            burst_len = $urandom_range(20, 110);
         end else if (pick < 13) begin
            burst_op = OP_TRACK;
            burst_len = $urandom_range(4, 40);
         end else if (pick < 16) begin
            burst_op = OP_PWM;
            burst_len = $urandom_range(1, 8);
         end else if (pick < 17) begin
            burst_op = OP_IDLE;
            burst_len = $urandom_range(1, 3);
         end else begin
            noise = 1'b1;
            burst_op = OP_IDLE;
            burst_len = $urandom_range(1, 12);
         end
         if (burst_len > left) burst_len = left;
         hold_ref = rand_current();
         for (k = 0; k < burst_len; k++) begin
            if (noise) t.op = opcode_type'(OP_W'($urandom_range(0, int'(OP_TRACK))));
            else t.op = burst_op;
            if ($urandom_range(0, 7) == 0) hold_ref = rand_current();
            t.sensor_ma = rand_current();
            t.ref_ma = hold_ref;
            t.open_loop_pct = rand_pct();
            send_tick(t, 1'b0, unused);
            left--;
            // Every so often the sender waits for the pipeline to run dry.
            if (ticks_sent % 150 == 75) drain_results();
         end
      end
   endtask

   // Every completed result transaction is matched against the oldest
   // expectation, field by field.
   always @(posedge clock) begin : check_results
      drive_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (pending_drives.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual duty %0d dir %0d effort %0d",
                     $time, rsp_bus.duty, rsp_bus.direction, rsp_bus.effort);
            mismatches++;
         end else begin
            want = pending_drives.pop_front();
            if (rsp_bus.duty !== want.duty) begin
               $display("%0t: duty mismatch, expected %0d, actual %0d",
                        $time, want.duty, rsp_bus.duty);
               mismatches++;
            end
            if (rsp_bus.direction !== want.direction) begin
               $display("%0t: direction mismatch, expected %0d, actual %0d",
                        $time, want.direction, rsp_bus.direction);
               mismatches++;
            end
            if (rsp_bus.effort !== want.effort) begin
               $display("%0t: effort mismatch, expected %0d, actual %0d",
                        $time, want.effort, rsp_bus.effort);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: any transaction on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: timeout, no transaction for %0d cycles, %0d results outstanding",
                  $time, QUIET_LIMIT, pending_drives.size());
         $display("FAIL motor_current_pi_controller_unit");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int r;
      int p;
      tick_type t;
      drive_type known;
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_IDLE;
      req_bus.sensor_ma = '0;
      req_bus.ref_ma = '0;
      req_bus.open_loop_pct = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_PROP_GAIN;
      csr_bus.wdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed rows, with the first idling pattern already in force.
      for (r = 0; r < DIRECTED_ROWS; r++) begin
         t.op = directed_rows[r].op;
         t.sensor_ma = CUR_W'(directed_rows[r].sensor_ma);
         t.ref_ma = CUR_W'(directed_rows[r].ref_ma);
         t.open_loop_pct = PCT_W'(directed_rows[r].open_loop_pct);
         known.duty = DUTY_W'(directed_rows[r].duty);
         known.direction = directed_rows[r].direction[0];
         known.effort = EFF_W'(directed_rows[r].effort);
         send_tick(t, directed_rows[r].has_known, known);
      end

      // Random phases. The idling pattern moves from a brisk sender with a
      // sluggish receiver, to the reverse, to both sides at full speed.
      gain_sets[4] = '{$urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, (1 << ILIM_W) - 1),
                       $urandom_range(0, (1 << CLIM_W) - 1)};
      for (p = 0; p < PHASE_COUNT; p++) begin
         apply_settings(gain_sets[p]);
         if (p < 2) begin
            feed_gap_pct = 22;
            rsp_stall_pct = 48;
         end else if (p < 4) begin
            feed_gap_pct = 48;
            rsp_stall_pct = 22;
         end else begin
            feed_gap_pct = 0;
            rsp_stall_pct = 0;
         end
         run_traffic(PHASE_TICKS);
      end

      // Let everything come back, then give a stray result time to appear.
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d ticks: %0d idle, %0d open-loop, %0d tune, %0d track.",
               ticks_sent, op_count[int'(OP_IDLE)], op_count[int'(OP_PWM)],
               op_count[int'(OP_TUNE)], op_count[int'(OP_TRACK)]);
      $display("Checked %0d results over %0d register sets (%0d writes); %0d mismatches.",
               results_seen, settings_used, reg_writes, mismatches);
      if (mismatches == 0) begin
         $display("PASS motor_current_pi_controller_unit");
      end else begin
         $display("FAIL motor_current_pi_controller_unit");
      end
      $finish;
   end

endmodule

`default_nettype wire
